/* rtl/rbt_pkg.sv */
// Shared types, constants and request codes for the ray versus box table block.
package rbt_pkg;

    // Field widths
    localparam int COORD_W   = 24;
    localparam int DIM_W     = 23;
    localparam int ANG_W     = 16;
    localparam int IDX_W     = 6;
    localparam int REQ_W     = 2;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    // Table sizes
    localparam int MAX_WALLS = 64;
    localparam int MAX_DOORS = 64;
    localparam int WALL_AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int DOOR_AW   = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1;

    // Datapath widths
    localparam int TFRAC  = 24;   // fraction bits of the segment parameter
    localparam int TRIG_W = 17;   // signed Q14 sine and cosine
    localparam int LOC_W  = 32;   // multiplier operands, local coordinates
    localparam int BOX_W  = 26;   // box edges and spans
    localparam int DIFF_W = 28;   // doubled offsets from a wall centre
    localparam int PROD_W = 64;   // products and sums of products

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WALL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DOOR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLAG  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_COUNT = 1'd1;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [IDX_W-1:0]          entry_index;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [DIM_W-1:0]          box_width;
        logic [DIM_W-1:0]          box_height;
        logic [ANG_W-1:0]          box_angle;
        logic                      open_flag;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
    } t_res;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        logic [ANG_W-1:0]          ang;
    } t_wall_ent;

    typedef struct packed {
        logic                      open;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
    } t_door_ent;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig_out;

    typedef struct packed {
        logic             done;
        logic [TFRAC-1:0] q;
    } t_div_out;

endpackage

/* rtl/rbt_trig.sv */
// Iterative Q14 sine and cosine of a binary angle, one small product per cycle.
module rbt_trig (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rbt_pkg::ANG_W-1:0] i_angle,
    output rbt_pkg::t_trig_out        o_res
);

    localparam logic [15:0] QUARTER = 16'd16384;
    localparam logic [15:0] POLY_A  = 16'd25736;
    localparam logic [15:0] POLY_B  = 16'd10512;
    localparam logic [15:0] POLY_C  = 16'd1160;

    logic                              r_busy;
    logic                              r_phase;
    logic [1:0]                        r_step;
    logic                              r_done;
    logic [rbt_pkg::ANG_W-1:0]         r_ang;
    logic [14:0]                       r_x2;
    logic [14:0]                       r_t;
    logic signed [rbt_pkg::TRIG_W-1:0] r_sin;
    logic signed [rbt_pkg::TRIG_W-1:0] r_cos;

    logic [rbt_pkg::ANG_W-1:0]         a_eff;
    logic [14:0]                       x;
    logic [15:0]                       mul_a;
    logic [15:0]                       mul_b;
    logic [31:0]                       prod;
    logic signed [rbt_pkg::TRIG_W-1:0] mag;
    logic signed [rbt_pkg::TRIG_W-1:0] res;

    // Cosine is the sine a quarter turn on; fold into the first quadrant
    assign a_eff = r_phase ? r_ang + QUARTER : r_ang;
    assign x     = a_eff[14] ? 15'(QUARTER - {2'b00, a_eff[13:0]}) : {1'b0, a_eff[13:0]};

    // Horner steps of the quarter-wave polynomial on one multiplier
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = {1'b0, x};
                mul_b = {1'b0, x};
            end
            2'd1: begin
                mul_a = POLY_C;
                mul_b = {1'b0, r_x2};
            end
            2'd2: begin
                mul_a = POLY_B - {1'b0, r_t};
                mul_b = {1'b0, r_x2};
            end
            default: begin
                mul_a = POLY_A - {1'b0, r_t};
                mul_b = {1'b0, x};
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign mag  = $signed(prod[30:14]);
    assign res  = a_eff[15] ? -mag : mag;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_step  <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_phase <= 1'b1;
                    if (r_phase) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ang <= i_angle;
        end
        if (r_busy) begin
            case (r_step)
                2'd0: r_x2 <= prod[28:14];
                2'd1: r_t  <= prod[28:14];
                2'd2: r_t  <= prod[28:14];
                default: begin
                    if (r_phase) begin
                        r_cos <= res;
                    end else begin
                        r_sin <= res;
                    end
                end
            endcase
        end
    end

    assign o_res.done  = r_done;
    assign o_res.sin_v = r_sin;
    assign o_res.cos_v = r_cos;

endmodule

/* rtl/rbt_div.sv */
// Restoring divider giving the fraction bits of num/den (num below den), one bit a cycle.
module rbt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbt_pkg::PROD_W-1:0] i_num,
    input  logic [rbt_pkg::PROD_W-1:0] i_den,
    output rbt_pkg::t_div_out          o_res
);

    localparam int CW = $clog2(rbt_pkg::TFRAC + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [rbt_pkg::PROD_W:0]   r_rem;
    logic [rbt_pkg::PROD_W-1:0] r_den;
    logic [rbt_pkg::TFRAC-1:0]  r_q;

    logic [rbt_pkg::PROD_W:0]   sh;
    logic                       ge;

    assign sh = {r_rem[rbt_pkg::PROD_W-1:0], 1'b0};
    assign ge = (sh >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(rbt_pkg::TFRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? sh - {1'b0, r_den} : sh;
            r_q   <= {r_q[rbt_pkg::TFRAC-2:0], ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.q    = r_q;

endmodule

/* rtl/ray_box_table_nearest_hit_unit.sv */
// Top level: box tables in memories, query sequencer, shared multiplier, output register.
//
//  channel | direction | handshake                  | payload
//  in      | in        | i_in_valid / o_in_ready    | i_in  (t_req)
//  out     | out       | o_out_valid / i_out_ready  | o_out (t_res)
//  cfg     | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Table writes go into memory as the request is accepted; a door flag change reads
// the entry, then writes it back with the new flag (read, modify, write back). A query
// visits each wall and then each closed door, edge by edge, on the shared multiplier;
// an edge hit short of the segment end also runs the one-bit-per-cycle divider.
// Reset is synchronous and clears the counts and control; tables need no clearing.
// A result waiting on the output does not stop table writes; a further query waits at its end.
module ray_box_table_nearest_hit_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rbt_pkg::t_req                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rbt_pkg::t_res                 o_out,
    input  logic                          i_cfg_we,
    input  logic [rbt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbt_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int PW = rbt_pkg::PROD_W;
    localparam int LW = rbt_pkg::LOC_W;
    localparam int BW = rbt_pkg::BOX_W;
    localparam int DW = rbt_pkg::DIFF_W;
    localparam int CW = rbt_pkg::COORD_W;
    localparam int NW = rbt_pkg::CNT_W;

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FLG_RD = 5'd1;
    localparam logic [4:0] S_FLG_WR = 5'd2;
    localparam logic [4:0] S_Q_WRD  = 5'd3;
    localparam logic [4:0] S_Q_WLD  = 5'd4;
    localparam logic [4:0] S_Q_TRIG = 5'd5;
    localparam logic [4:0] S_Q_ROT  = 5'd6;
    localparam logic [4:0] S_Q_DRD  = 5'd7;
    localparam logic [4:0] S_Q_DLD  = 5'd8;
    localparam logic [4:0] S_E_M    = 5'd9;
    localparam logic [4:0] S_E_SGN  = 5'd10;
    localparam logic [4:0] S_E_CHK  = 5'd11;
    localparam logic [4:0] S_E_DIV  = 5'd12;
    localparam logic [4:0] S_F_MX   = 5'd13;
    localparam logic [4:0] S_F_MY   = 5'd14;
    localparam logic [4:0] S_F_OUT  = 5'd15;

    localparam logic [rbt_pkg::TFRAC:0] T_ONE = (rbt_pkg::TFRAC + 1)'(1) << rbt_pkg::TFRAC;
    localparam logic signed [PW-1:0] ROT_HALF = PW'(8192);
    localparam logic signed [PW-1:0] T_HALF   = PW'(1) <<< (rbt_pkg::TFRAC - 1);
    localparam logic signed [PW-1:0] C_HI     = (PW'(1) <<< (CW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] C_LO     = -C_HI - PW'(1);

    // Clamp to the coordinate range
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = v;
        if (c > C_HI) begin
            c = C_HI;
        end
        if (c < C_LO) begin
            c = C_LO;
        end
        return CW'(c);
    endfunction

    // Control registers
    logic [4:0]    r_state, n_state;
    logic [NW-1:0] r_wall_cnt, r_door_cnt;
    logic          r_out_valid, n_out_valid;

    // Payload and working registers
    rbt_pkg::t_res                     r_out, n_out;
    logic [NW-1:0]                     r_idx, n_idx;
    logic                              r_in_doors, n_in_doors;
    logic                              r_flag, n_flag;
    logic signed [CW-1:0]              r_sx, r_sy, r_ex, r_ey;
    logic signed [CW-1:0]              n_sx, n_sy, n_ex, n_ey;
    logic [rbt_pkg::TFRAC:0]           r_best, n_best;
    logic signed [DW-1:0]              r_dsx, r_dsy, r_dex, r_dey;
    logic signed [DW-1:0]              n_dsx, n_dsy, n_dex, n_dey;
    logic signed [rbt_pkg::TRIG_W-1:0] r_sin, r_cos, n_sin, n_cos;
    logic [2:0]                        r_step, n_step;
    logic signed [PW-1:0]              r_acc, n_acc;
    logic signed [LW-1:0]              r_px, r_py, r_rx, r_ry;
    logic signed [LW-1:0]              n_px, n_py, n_rx, n_ry;
    logic signed [BW-1:0]              r_left, r_right, r_top, r_bot, r_sw, r_sh;
    logic signed [BW-1:0]              n_left, n_right, n_top, n_bot, n_sw, n_sh;
    logic [1:0]                        r_edge, n_edge;
    logic signed [PW-1:0]              r_den, r_tn, r_un, n_den, n_tn, n_un;
    logic signed [CW-1:0]              r_hx, n_hx;

    // Memories
    rbt_pkg::t_wall_ent wall_mem [rbt_pkg::MAX_WALLS];
    rbt_pkg::t_door_ent door_mem [rbt_pkg::MAX_DOORS];
    rbt_pkg::t_wall_ent r_wall_q, wall_wdata;
    rbt_pkg::t_door_ent r_door_q, door_wdata;
    logic                        wall_we, door_we;
    logic [rbt_pkg::WALL_AW-1:0] wall_waddr, wall_raddr;
    logic [rbt_pkg::DOOR_AW-1:0] door_waddr, door_raddr;

    // Combinational helpers
    logic                       in_acc;
    logic                       wall_ok, door_ok;
    logic [NW-1:0]              n_walls, n_doors, idx_nx;
    logic signed [LW-1:0]       mul_a, mul_b;
    logic signed [PW-1:0]       mul_p;
    logic signed [PW-1:0]       rot_sum;
    logic signed [LW-1:0]       rot_val;
    logic signed [PW-1:0]       fin_sum;
    logic signed [BW-1:0]       qx, qy, es;
    logic                       horiz;
    logic signed [LW-1:0]       wx, wy;
    logic signed [CW:0]         dxv, dyv;
    logic signed [CW:0]         wl, hl;
    logic signed [DW-1:0]       cx2, cy2;
    logic                       hit, tn_eq;
    logic                       go_next_edge, go_next_box;
    logic                       walls_done;
    logic [4:0]                 after_box;
    logic                       trig_start, div_start;
    rbt_pkg::t_trig_out         trig_o;
    rbt_pkg::t_div_out          div_o;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign wall_ok    = int'(i_in.entry_index) < rbt_pkg::MAX_WALLS;
    assign door_ok    = int'(i_in.entry_index) < rbt_pkg::MAX_DOORS;

    // Counts saturate at the table sizes
    assign n_walls = (r_wall_cnt > NW'(rbt_pkg::MAX_WALLS)) ? NW'(rbt_pkg::MAX_WALLS)
                                                            : r_wall_cnt;
    assign n_doors = (r_door_cnt > NW'(rbt_pkg::MAX_DOORS)) ? NW'(rbt_pkg::MAX_DOORS)
                                                            : r_door_cnt;
    assign idx_nx  = r_idx + NW'(1);

    // Wall table
    assign wall_we    = in_acc && (i_in.req_type == rbt_pkg::REQ_WALL) && wall_ok;
    assign wall_waddr = rbt_pkg::WALL_AW'(i_in.entry_index);
    assign wall_raddr = r_idx[rbt_pkg::WALL_AW-1:0];
    assign wall_wdata = '{x: i_in.box_x, y: i_in.box_y, w: i_in.box_width,
                          h: i_in.box_height, ang: i_in.box_angle};

    always_ff @(posedge i_clk) begin
        if (wall_we) begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        r_wall_q <= wall_mem[wall_raddr];
    end

    // Door table: whole-entry writes, or flag write-back after a read
    always_comb begin
        if (r_state == S_FLG_WR) begin
            door_we    = 1'b1;
            door_waddr = r_idx[rbt_pkg::DOOR_AW-1:0];
            door_wdata = r_door_q;
            door_wdata.open = r_flag;
        end else begin
            door_we    = in_acc && (i_in.req_type == rbt_pkg::REQ_DOOR) && door_ok;
            door_waddr = rbt_pkg::DOOR_AW'(i_in.entry_index);
            door_wdata = '{open: i_in.open_flag, x: i_in.box_x, y: i_in.box_y,
                           w: i_in.box_width, h: i_in.box_height};
        end
    end
    assign door_raddr = r_idx[rbt_pkg::DOOR_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (door_we) begin
            door_mem[door_waddr] <= door_wdata;
        end
        r_door_q <= door_mem[door_raddr];
    end

    // Units
    assign trig_start = (r_state == S_Q_WLD);

    rbt_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (r_wall_q.ang),
        .o_res   (trig_o)
    );

    rbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (PW'(r_tn)),
        .i_den   (PW'(r_den)),
        .o_res   (div_o)
    );

    // Edge geometry: top, right, bottom, left
    always_comb begin
        case (r_edge)
            2'd0: begin
                qx = r_left;  qy = r_top; es = r_sw;  horiz = 1'b1;
            end
            2'd1: begin
                qx = r_right; qy = r_top; es = r_sh;  horiz = 1'b0;
            end
            2'd2: begin
                qx = r_right; qy = r_bot; es = -r_sw; horiz = 1'b1;
            end
            default: begin
                qx = r_left;  qy = r_bot; es = -r_sh; horiz = 1'b0;
            end
        endcase
    end
    assign wx = LW'(qx) - r_px;
    assign wy = LW'(qy) - r_py;

    assign dxv = (CW + 1)'(r_ex) - (CW + 1)'(r_sx);
    assign dyv = (CW + 1)'(r_ey) - (CW + 1)'(r_sy);

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_Q_ROT: begin
                mul_b = r_step[0] ? LW'(r_sin) : LW'(r_cos);
                case (r_step)
                    3'd0, 3'd3: mul_a = LW'(r_dsx);
                    3'd1, 3'd2: mul_a = LW'(r_dsy);
                    3'd4, 3'd7: mul_a = LW'(r_dex);
                    default:    mul_a = LW'(r_dey);
                endcase
            end
            S_E_M: begin
                case (r_step[1:0])
                    2'd0: begin
                        mul_a = horiz ? -r_ry : r_rx;
                        mul_b = LW'(es);
                    end
                    2'd1: begin
                        mul_a = horiz ? -wy : wx;
                        mul_b = LW'(es);
                    end
                    2'd2: begin
                        mul_a = wx;
                        mul_b = r_ry;
                    end
                    default: begin
                        mul_a = wy;
                        mul_b = r_rx;
                    end
                endcase
            end
            S_F_MX: begin
                mul_a = LW'(r_best);
                mul_b = LW'(dxv);
            end
            S_F_MY: begin
                mul_a = LW'(r_best);
                mul_b = LW'(dyv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Rotation rounding (half up from Q14) and final interpolation
    assign rot_sum = (r_step[1] ? r_acc - mul_p : r_acc + mul_p) + ROT_HALF;
    assign rot_val = LW'(rot_sum >>> 14);
    assign fin_sum = ((mul_p + T_HALF) >>> rbt_pkg::TFRAC)
                     + ((r_state == S_F_MX) ? PW'(r_sx) : PW'(r_sy));

    // Wall centre offsets in doubled units
    assign wl  = $signed((CW + 1)'(r_wall_q.w));
    assign hl  = $signed((CW + 1)'(r_wall_q.h));
    assign cx2 = (DW'(r_wall_q.x) <<< 1) + DW'(wl);
    assign cy2 = (DW'(r_wall_q.y) <<< 1) + DW'(hl);

    // Edge test after sign normalisation
    assign hit = (r_den != '0) && !r_tn[PW-1] && (r_tn <= r_den)
                 && !r_un[PW-1] && (r_un <= r_den);
    assign tn_eq     = (r_tn == r_den);
    assign div_start = (r_state == S_E_CHK) && hit && !tn_eq;

    // Where to go once a box is finished
    assign walls_done = !(idx_nx < n_walls);
    always_comb begin
        if (!r_in_doors) begin
            if (!walls_done) begin
                after_box = S_Q_WRD;
            end else if (n_doors != '0) begin
                after_box = S_Q_DRD;
            end else begin
                after_box = S_F_MX;
            end
        end else begin
            after_box = (idx_nx < n_doors) ? S_Q_DRD : S_F_MX;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_idx       = r_idx;
        n_in_doors  = r_in_doors;
        n_flag      = r_flag;
        n_sx = r_sx; n_sy = r_sy; n_ex = r_ex; n_ey = r_ey;
        n_best      = r_best;
        n_dsx = r_dsx; n_dsy = r_dsy; n_dex = r_dex; n_dey = r_dey;
        n_sin = r_sin; n_cos = r_cos;
        n_step      = r_step;
        n_acc       = r_acc;
        n_px = r_px; n_py = r_py; n_rx = r_rx; n_ry = r_ry;
        n_left = r_left; n_right = r_right; n_top = r_top; n_bot = r_bot;
        n_sw = r_sw; n_sh = r_sh;
        n_edge      = r_edge;
        n_den = r_den; n_tn = r_tn; n_un = r_un;
        n_hx        = r_hx;
        go_next_edge = 1'b0;
        go_next_box  = 1'b0;

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx  = NW'(i_in.entry_index);
                    n_flag = i_in.open_flag;
                    n_sx = i_in.start_x; n_sy = i_in.start_y;
                    n_ex = i_in.end_x;   n_ey = i_in.end_y;
                    if (i_in.req_type == rbt_pkg::REQ_FLAG) begin
                        if (door_ok) begin
                            n_state = S_FLG_RD;
                        end
                    end else if (i_in.req_type == rbt_pkg::REQ_QUERY) begin
                        n_best = T_ONE;
                        n_idx  = '0;
                        if (n_walls != '0) begin
                            n_in_doors = 1'b0;
                            n_state    = S_Q_WRD;
                        end else if (n_doors != '0) begin
                            n_in_doors = 1'b1;
                            n_state    = S_Q_DRD;
                        end else begin
                            n_state = S_F_MX;
                        end
                    end
                end
            end
            S_FLG_RD: n_state = S_FLG_WR;
            S_FLG_WR: n_state = S_IDLE;
            S_Q_WRD:  n_state = S_Q_WLD;
            S_Q_WLD: begin
                n_dsx = (DW'(r_sx) <<< 1) - cx2;
                n_dsy = (DW'(r_sy) <<< 1) - cy2;
                n_dex = (DW'(r_ex) <<< 1) - cx2;
                n_dey = (DW'(r_ey) <<< 1) - cy2;
                n_left  = -BW'(wl);
                n_right = BW'(wl);
                n_top   = -BW'(hl);
                n_bot   = BW'(hl);
                n_sw    = BW'(wl) <<< 1;
                n_sh    = BW'(hl) <<< 1;
                n_state = S_Q_TRIG;
            end
            S_Q_TRIG: begin
                if (trig_o.done) begin
                    n_sin   = trig_o.sin_v;
                    n_cos   = trig_o.cos_v;
                    n_step  = '0;
                    n_state = S_Q_ROT;
                end
            end
            S_Q_ROT: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0, 3'd2, 3'd4, 3'd6: n_acc = mul_p;
                    3'd1: n_px = rot_val;
                    3'd3: n_py = rot_val;
                    3'd5: n_rx = rot_val - r_px;
                    default: begin
                        n_ry    = rot_val - r_py;
                        n_edge  = '0;
                        n_step  = '0;
                        n_state = S_E_M;
                    end
                endcase
            end
            S_Q_DRD: n_state = S_Q_DLD;
            S_Q_DLD: begin
                n_px = LW'(r_sx);
                n_py = LW'(r_sy);
                n_rx = LW'(r_ex) - LW'(r_sx);
                n_ry = LW'(r_ey) - LW'(r_sy);
                n_left  = BW'(r_door_q.x);
                n_right = BW'(r_door_q.x) + BW'(r_door_q.w);
                n_top   = BW'(r_door_q.y);
                n_bot   = BW'(r_door_q.y) + BW'(r_door_q.h);
                n_sw    = BW'(r_door_q.w);
                n_sh    = BW'(r_door_q.h);
                n_edge  = '0;
                n_step  = '0;
                if (r_door_q.open) begin
                    go_next_box = 1'b1;
                end else begin
                    n_state = S_E_M;
                end
            end
            S_E_M: begin
                n_step = r_step + 3'd1;
                case (r_step[1:0])
                    2'd0: n_den = mul_p;
                    2'd1: n_tn  = mul_p;
                    2'd2: n_un  = mul_p;
                    default: begin
                        n_un    = r_un - mul_p;
                        n_state = S_E_SGN;
                    end
                endcase
            end
            S_E_SGN: begin
                if (r_den[PW-1]) begin
                    n_den = -r_den;
                    n_tn  = -r_tn;
                    n_un  = -r_un;
                end
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                // a hit at the end point never beats the current best
                if (div_start) begin
                    n_state = S_E_DIV;
                end else begin
                    go_next_edge = 1'b1;
                end
            end
            S_E_DIV: begin
                if (div_o.done) begin
                    if ({1'b0, div_o.q} < r_best) begin
                        n_best = {1'b0, div_o.q};
                    end
                    go_next_edge = 1'b1;
                end
            end
            S_F_MX: begin
                n_hx    = sat_coord(fin_sum);
                n_state = S_F_MY;
            end
            S_F_MY: begin
                // operands stay put while the result register is still occupied
                if (!r_out_valid || i_out_ready) begin
                    n_out.hit_x = r_hx;
                    n_out.hit_y = sat_coord(fin_sum);
                    n_state     = S_F_OUT;
                end
            end
            S_F_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Edge and box stepping
        if (go_next_edge) begin
            if (r_edge == 2'd3) begin
                go_next_box = 1'b1;
            end else begin
                n_edge  = r_edge + 2'd1;
                n_step  = '0;
                n_state = S_E_M;
            end
        end
        if (go_next_box) begin
            n_state = after_box;
            if (!r_in_doors && walls_done) begin
                n_idx      = '0;
                n_in_doors = 1'b1;
            end else begin
                n_idx = idx_nx;
            end
        end
    end

    // Result register holds the finished transaction; S_F_MY writes it only once free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wall_cnt  <= '0;
            r_door_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == rbt_pkg::CFG_WALL_COUNT) begin
                r_wall_cnt <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == rbt_pkg::CFG_DOOR_COUNT) begin
                r_door_cnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state != S_F_MY || !r_out_valid || i_out_ready) begin
            r_out <= n_out;
        end
        r_idx      <= n_idx;
        r_in_doors <= n_in_doors;
        r_flag     <= n_flag;
        r_sx <= n_sx; r_sy <= n_sy; r_ex <= n_ex; r_ey <= n_ey;
        r_best     <= n_best;
        r_dsx <= n_dsx; r_dsy <= n_dsy; r_dex <= n_dex; r_dey <= n_dey;
        r_sin <= n_sin; r_cos <= n_cos;
        r_step     <= n_step;
        r_acc      <= n_acc;
        r_px <= n_px; r_py <= n_py; r_rx <= n_rx; r_ry <= n_ry;
        r_left <= n_left; r_right <= n_right; r_top <= n_top; r_bot <= n_bot;
        r_sw <= n_sw; r_sh <= n_sh;
        r_edge     <= n_edge;
        r_den <= n_den; r_tn <= n_tn; r_un <= n_un;
        r_hx       <= n_hx;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // The trig unit reports only while the sequencer waits for it
    a_trig_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_o.done |-> (r_state == S_Q_TRIG))
        else $error("trig result outside wait state");

    // The divider reports only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_o.done |-> (r_state == S_E_DIV))
        else $error("divider result outside wait state");

    // Nearest parameter never passes the end point
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_DIV) |-> (r_best <= T_ONE))
        else $error("best parameter beyond segment end");

    // A finished query lands in the output register and frees the input
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_OUT && (!r_out_valid || i_out_ready))
        |=> (o_out_valid && o_in_ready))
        else $error("finished query not presented");
`endif

endmodule

/* bench/tb_ray_box_table_nearest_hit_unit.sv */
// Self-checking testbench for the ray versus box table nearest-hit unit.
module tb_ray_box_table_nearest_hit_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  QUIET_LIMIT = 200000;
    localparam int  REGION      = 30000;
    localparam longint T_ONE    = 64'sd1 << rbt_pkg::TFRAC;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    rbt_pkg::t_req i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    rbt_pkg::t_res o_out;
    logic i_cfg_we = 1'b0;
    logic [rbt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rbt_pkg::CFG_W-1:0] i_cfg_data = '0;

    // Predictor state: table contents and counts as the block should hold them
    rbt_pkg::t_wall_ent   wall_tab [rbt_pkg::MAX_WALLS];
    rbt_pkg::t_door_ent   door_tab [rbt_pkg::MAX_DOORS];
    logic [rbt_pkg::CNT_W-1:0] wall_lim = '0;
    logic [rbt_pkg::CNT_W-1:0] door_lim = '0;

    rbt_pkg::t_res hit_due_q[$];
    int   n_err = 0;
    int   n_sent = 0;
    int   n_hits_checked = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   quiet = 0;

    ray_box_table_nearest_hit_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Sine approximation, Q14, quarter wave
    function automatic longint quarter_wave(longint x);
        longint x2, t;
        x2 = (x * x) >>> 14;
        t  = (1160 * x2) >>> 14;
        t  = ((10512 - t) * x2) >>> 14;
        t  = 25736 - t;
        return (t * x) >>> 14;
    endfunction

    function automatic longint sin_q14(logic [rbt_pkg::ANG_W-1:0] a);
        longint f, v;
        f = longint'(a[13:0]);
        v = a[14] ? quarter_wave(16384 - f) : quarter_wave(f);
        return a[15] ? -v : v;
    endfunction

    // Segment p+t*r against edge q+u*s; t as a TFRAC-bit fraction
    function automatic bit seg_cross(longint px, longint py, longint rx, longint ry,
                                     longint qx, longint qy, longint sx, longint sy,
                                     output longint tq);
        longint den, wx, wy, tn, un, quo, rem;
        tq  = 0;
        den = rx * sy - ry * sx;
        wx  = qx - px;
        wy  = qy - py;
        tn  = wx * sy - wy * sx;
        un  = wx * ry - wy * rx;
        if (den == 0) return 1'b0;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den) return 1'b0;
        if (tn == den) begin
            tq = T_ONE;
            return 1'b1;
        end
        quo = 0;
        rem = tn;
        for (int i = 0; i < rbt_pkg::TFRAC; i++) begin
            rem = rem <<< 1;
            quo = quo <<< 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        tq = quo;
        return 1'b1;
    endfunction

    // Edges of a rectangle in order: top, right, bottom, left
    function automatic void scan_rect(longint px, longint py, longint rx, longint ry,
                                      longint xa, longint ya, longint xb, longint yb,
                                      inout longint best);
        longint t;
        if (seg_cross(px, py, rx, ry, xa, ya, xb - xa, 0, t) && t < best) best = t;
        if (seg_cross(px, py, rx, ry, xb, ya, 0, yb - ya, t) && t < best) best = t;
        if (seg_cross(px, py, rx, ry, xb, yb, xa - xb, 0, t) && t < best) best = t;
        if (seg_cross(px, py, rx, ry, xa, yb, 0, ya - yb, t) && t < best) best = t;
    endfunction

    function automatic logic [rbt_pkg::COORD_W-1:0] clamp_coord(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (rbt_pkg::COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[rbt_pkg::COORD_W-1:0];
    endfunction

    // Nearest hit over walls in their own frame, then closed doors
    function automatic rbt_pkg::t_res trace_ray(rbt_pkg::t_req r);
        longint best, sx, sy, ex, ey, c, s, w, h, cx2, cy2;
        longint dsx, dsy, dex, dey, lsx, lsy, lex, ley, x0, y0;
        int nw, nd;
        rbt_pkg::t_res res;
        best = T_ONE;
        sx = r.start_x;
        sy = r.start_y;
        ex = r.end_x;
        ey = r.end_y;
        nw = (wall_lim > rbt_pkg::MAX_WALLS) ? rbt_pkg::MAX_WALLS : int'(wall_lim);
        nd = (door_lim > rbt_pkg::MAX_DOORS) ? rbt_pkg::MAX_DOORS : int'(door_lim);
        for (int i = 0; i < nw; i++) begin
            c   = sin_q14(wall_tab[i].ang + 16'h4000);
            s   = sin_q14(wall_tab[i].ang);
            w   = longint'(wall_tab[i].w);
            h   = longint'(wall_tab[i].h);
            x0  = wall_tab[i].x;
            y0  = wall_tab[i].y;
            cx2 = 2 * x0 + w;
            cy2 = 2 * y0 + h;
            dsx = 2 * sx - cx2;
            dsy = 2 * sy - cy2;
            dex = 2 * ex - cx2;
            dey = 2 * ey - cy2;
            lsx = (dsx * c + dsy * s + 8192) >>> 14;
            lsy = (dsy * c - dsx * s + 8192) >>> 14;
            lex = (dex * c + dey * s + 8192) >>> 14;
            ley = (dey * c - dex * s + 8192) >>> 14;
            scan_rect(lsx, lsy, lex - lsx, ley - lsy, -w, -h, w, h, best);
        end
        for (int i = 0; i < nd; i++) begin
            if (!door_tab[i].open) begin
                x0 = door_tab[i].x;
                y0 = door_tab[i].y;
                scan_rect(sx, sy, ex - sx, ey - sy, x0, y0,
                          x0 + longint'(door_tab[i].w), y0 + longint'(door_tab[i].h), best);
            end
        end
        res.hit_x = clamp_coord(sx + ((best * (ex - sx) + (T_ONE / 2)) >>> rbt_pkg::TFRAC));
        res.hit_y = clamp_coord(sy + ((best * (ey - sy) + (T_ONE / 2)) >>> rbt_pkg::TFRAC));
        return res;
    endfunction

    // Apply one accepted transaction to the predictor
    function automatic void absorb_req(rbt_pkg::t_req r);
        case (r.req_type)
            rbt_pkg::REQ_WALL: begin
                wall_tab[r.entry_index] = '{x: r.box_x, y: r.box_y, w: r.box_width,
                                            h: r.box_height, ang: r.box_angle};
            end
            rbt_pkg::REQ_DOOR: begin
                door_tab[r.entry_index] = '{open: r.open_flag, x: r.box_x, y: r.box_y,
                                            w: r.box_width, h: r.box_height};
            end
            rbt_pkg::REQ_FLAG: door_tab[r.entry_index].open = r.open_flag;
            default:  hit_due_q.push_back(trace_ray(r));
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        rbt_pkg::t_res exp_hit;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hit_due_q.size() == 0) begin
                $error("result with none expected: hit_x %0d hit_y %0d", o_out.hit_x, o_out.hit_y);
                n_err++;
            end else begin
                exp_hit = hit_due_q.pop_front();
                n_hits_checked++;
                if (o_out.hit_x !== exp_hit.hit_x) begin
                    $error("hit_x expected %0d actual %0d", exp_hit.hit_x, o_out.hit_x);
                    n_err++;
                end
                if (o_out.hit_y !== exp_hit.hit_y) begin
                    $error("hit_y expected %0d actual %0d", exp_hit.hit_y, o_out.hit_y);
                    n_err++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Send one transaction; called and returns at a falling edge
    task automatic send_req(input rbt_pkg::t_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_req(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Wait for every expected result, then let trailing writes settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (hit_due_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [rbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbt_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == rbt_pkg::CFG_WALL_COUNT) wall_lim = val;
        else                                door_lim = val;
    endtask

    function automatic logic [rbt_pkg::COORD_W-1:0] near_coord(int span);
        return rbt_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic rbt_pkg::t_req mk_req(logic [rbt_pkg::REQ_W-1:0] kind, int idx,
                                             int bx, int by, int bw, int bh, int ang, bit opn,
                                             int sx, int sy, int ex, int ey);
        rbt_pkg::t_req r;
        r = '{req_type: kind, entry_index: rbt_pkg::IDX_W'(idx),
              box_x: rbt_pkg::COORD_W'(bx), box_y: rbt_pkg::COORD_W'(by),
              box_width: rbt_pkg::DIM_W'(bw), box_height: rbt_pkg::DIM_W'(bh),
              box_angle: rbt_pkg::ANG_W'(ang), open_flag: opn,
              start_x: rbt_pkg::COORD_W'(sx), start_y: rbt_pkg::COORD_W'(sy),
              end_x: rbt_pkg::COORD_W'(ex), end_y: rbt_pkg::COORD_W'(ey)};
        return r;
    endfunction

    // Mostly well-placed boxes and rays near the origin, some full-range noise
    function automatic rbt_pkg::t_req rand_req();
        rbt_pkg::t_req r;
        int pick;
        logic [287:0] noise;
        pick = $urandom_range(0, 99);
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        r.req_type    = rbt_pkg::REQ_W'($urandom);
        r.entry_index = rbt_pkg::IDX_W'($urandom);
        r.box_x       = near_coord(REGION);
        r.box_y       = near_coord(REGION);
        r.box_width   = rbt_pkg::DIM_W'($urandom_range(0, 12000));
        r.box_height  = rbt_pkg::DIM_W'($urandom_range(0, 12000));
        r.box_angle   = rbt_pkg::ANG_W'($urandom);
        r.open_flag   = 1'($urandom_range(0, 1));
        r.start_x     = near_coord(2 * REGION);
        r.start_y     = near_coord(2 * REGION);
        r.end_x       = near_coord(2 * REGION);
        r.end_y       = near_coord(2 * REGION);
        if (pick < 45)      r.req_type = rbt_pkg::REQ_QUERY;
        else if (pick < 60) r.req_type = rbt_pkg::REQ_WALL;
        else if (pick < 75) r.req_type = rbt_pkg::REQ_DOOR;
        else if (pick < 85) r.req_type = rbt_pkg::REQ_FLAG;
        else                r = noise[$bits(rbt_pkg::t_req)-1:0];
        return r;
    endfunction

    // Load every table entry so that no query reads an unwritten one
    task automatic test_fill_tables();
        rbt_pkg::t_req r;
        for (int i = 0; i < rbt_pkg::MAX_WALLS + rbt_pkg::MAX_DOORS; i++) begin
            r = rand_req();
            r.req_type    = (i < rbt_pkg::MAX_WALLS) ? rbt_pkg::REQ_WALL : rbt_pkg::REQ_DOOR;
            r.entry_index = rbt_pkg::IDX_W'(i);
            send_req(r);
        end
        drain();
    endtask

    // Directed cases: edges, rotations, open flag, degenerate rays, ties, extremes
    task automatic test_directed();
        cfg_write(rbt_pkg::CFG_WALL_COUNT, 7'd1);
        cfg_write(rbt_pkg::CFG_DOOR_COUNT, 7'd2);
        send_req(mk_req(rbt_pkg::REQ_WALL, 0, 0, 0, 2560, 1280, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_DOOR, 0, 5120, 0, 256, 2560, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_DOOR, 1, 0, 0, 2560, 1280, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, -2560, 640, 10240, 640));
        // zero-length ray, then a ray collinear with a top edge
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 500, 500, 500, 500));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, -2560, 0, 10240, 0));
        // door open then closed again
        send_req(mk_req(rbt_pkg::REQ_FLAG, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 4000, 640, 8000, 640));
        send_req(mk_req(rbt_pkg::REQ_FLAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 4000, 640, 8000, 640));
        // wall at zero, a quarter and a half turn, then at the largest angle
        for (int k = 0; k < 4; k++) begin
            send_req(mk_req(rbt_pkg::REQ_WALL, 0, 0, 0, 2560, 1280,
                            (k == 3) ? 16'hFFFF : k * 16'h4000, 0, 0, 0, 0, 0));
            send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 1280, -5000, 1300, 5000));
        end
        // door of the largest size from the lowest corner, extreme ray ends
        send_req(mk_req(rbt_pkg::REQ_DOOR, 1, -8388608, -8388608, 8388607, 8388607, 0, 0,
                        0, 0, 0, 0));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0,
                        8388607, -8388608, -8388608, 8388607));
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0,
                        -8388608, -8388608, 8388607, 8388607));
        drain();
    endtask

    // Counts at zero, at the table size and beyond it
    task automatic test_count_limits();
        cfg_write(rbt_pkg::CFG_WALL_COUNT, 7'd0);
        cfg_write(rbt_pkg::CFG_DOOR_COUNT, 7'd0);
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0,
                        -8388608, 8388607, 8388607, -8388608));
        drain();
        cfg_write(rbt_pkg::CFG_WALL_COUNT, 7'd127);
        cfg_write(rbt_pkg::CFG_DOOR_COUNT, 7'd127);
        send_req(mk_req(rbt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, -60000, -1000, 60000, 1000));
        drain();
        cfg_write(rbt_pkg::CFG_WALL_COUNT, 7'd64);
        cfg_write(rbt_pkg::CFG_DOOR_COUNT, 7'd64);
        for (int i = 0; i < 6; i++) send_req(rand_req());
        drain();
    endtask

    // Random traffic in phases, each with its own table counts
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int phases, input int per_phase);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int p = 0; p < phases; p++) begin
            cfg_write(rbt_pkg::CFG_WALL_COUNT, rbt_pkg::CFG_W'($urandom_range(0, 6)));
            cfg_write(rbt_pkg::CFG_DOOR_COUNT, rbt_pkg::CFG_W'($urandom_range(0, 6)));
            for (int i = 0; i < per_phase; i++) send_req(rand_req());
            drain();
        end
    endtask

    // Sender holds off until the block has delivered everything
    task automatic test_hold_off();
        rbt_pkg::t_req r;
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        for (int i = 0; i < 10; i++) begin
            r = rand_req();
            r.req_type = rbt_pkg::REQ_QUERY;
            send_req(r);
            drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_fill_tables();
        test_directed();
        test_count_limits();
        test_random_traffic(10, 61, 4, 82);
        test_random_traffic(61, 10, 4, 82);
        test_random_traffic(0, 0, 4, 82);
        test_hold_off();
        drain();
        repeat (50) @(negedge i_clk);
        $display("covered %0d input transactions, %0d hit results checked,", n_sent,
                 n_hits_checked);
        $display("counts from zero to beyond table size, three idling patterns");
        if (n_err == 0 && hit_due_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/rbt_pkg.sv
rtl/rbt_trig.sv
rtl/rbt_div.sv
rtl/ray_box_table_nearest_hit_unit.sv
bench/tb_ray_box_table_nearest_hit_unit.sv
